// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the scheduler.
// Needs nothing else; every macro takes its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: rtl/zots_pkg.sv
// Shared constants and helpers of the Z-order tile job scheduler.
// Used by the top level and its checker; depends on nothing.
package zots_pkg;

    localparam int GRID_LOG2 = 6;
    localparam int GRID_SIDE = 1 << GRID_LOG2;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int COORD_W = 6;
    localparam int CUR_W = 2 * GRID_LOG2 + 1;
    localparam int SIDE_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_FETCH_CPU = 2'd2;
    localparam logic [1:0] OP_FETCH_GPU = 2'd3;

    localparam logic [1:0] CLS_CPU = 2'd0;
    localparam logic [1:0] CLS_DRAW = 2'd1;
    localparam logic [1:0] CLS_TILE = 2'd2;
    localparam logic [1:0] CLS_MISC = 2'd3;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_GIVEN = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_SQUARE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 3'd3;

    // Queue slot of a job class; tile jobs never reach a queue.
    function automatic logic [1:0] queue_of(input logic [1:0] cls);
        logic [1:0] q;
        case (cls)
            CLS_CPU: q = 2'd0;
            CLS_DRAW: q = 2'd1;
            default: q = 2'd2;
        endcase
        return q;
    endfunction

    // Ceiling log2 of a side already saturated to the grid.
    function automatic logic [2:0] side_log2(input logic [SIDE_W-1:0] m);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if ((SIDE_W'(1) << i) < m) begin
                r = 3'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/z_order_tile_job_scheduler_top.sv
// Top level of the Z-order tile job scheduler: sequencer, job queues and tile map.
// Depends on zots_pkg.
//
// Channel  Direction  Handshake             Payload
// in       request    in_valid / in_ready   operation job_class job_number tile_x tile_y
// out      result     out_valid / out_ready status given_class given_number given_x given_y
// cfg      write      cfg_valid / cfg_ready cfg_index cfg_data
//
// One request is worked at a time; in_ready is high only while the sequencer idles.
// From one accepted request to the next: start, queue add and an empty CPU fetch pass
// S_EXEC and S_FINISH; tile add adds S_MAP_WR, and a fetch from a queue S_FIFO_OUT.
// A GPU fetch that reaches the tile map passes S_SCAN_RD and S_SCAN_CHK per Z-order
// position (one tile-map row read and one bit check), up to 4096 over a 64x64 square.
// A result sits in the output register until taken, while the next request runs; a
// second result waits in the last sequencer state until the register frees up.
// Reset clears the queues, the cursor and the per-row valid bits of the tile map
// at once, so no clearing pass is needed; start-scene does the same in S_EXEC.
module z_order_tile_job_scheduler_top
    import zots_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int JOB_ID_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             operation,
    input  logic [1:0]             job_class,
    input  logic [JOB_ID_BITS-1:0] job_number,
    input  logic [COORD_W-1:0]     tile_x,
    input  logic [COORD_W-1:0]     tile_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [1:0]             given_class,
    output logic [JOB_ID_BITS-1:0] given_number,
    output logic [COORD_W-1:0]     given_x,
    output logic [COORD_W-1:0]     given_y,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int ENT_W = JOB_ID_BITS + 2 * COORD_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_MAP_WR   = 8'b0000_0100,
        S_FIFO_OUT = 8'b0000_1000,
        S_SCAN_RD  = 8'b0001_0000,
        S_SCAN_CHK = 8'b0010_0000,
        S_TILE_OUT = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SIDE_W-1:0] scene_width_reg, scene_height_reg;
    logic              whole_square_reg;
    logic [2:0]        block_log_reg;

    // Latched request.
    logic [1:0]             req_op_reg, req_cls_reg;
    logic [JOB_ID_BITS-1:0] req_num_reg;
    logic [COORD_W-1:0]     req_x_reg, req_y_reg;

    // Queue pointers.
    logic [PTR_W-1:0] head_reg [3];
    logic [CNT_W-1:0] count_reg [3];
    logic [PTR_W-1:0] head_next [3];
    logic [CNT_W-1:0] count_next [3];
    logic [ENT_W-1:0] fifo_rdata [3];
    logic [2:0]       fifo_we, fifo_re;
    logic [PTR_W-1:0] wslot;
    logic [SUM_W-1:0] slot_sum;
    logic             push_en, pop_en;
    logic [1:0]       push_q, pop_q;

    // Tile map: one word per row, a valid bit per row, and the job store.
    logic [GRID_SIDE-1:0]   map_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0]   map_rdata_reg, map_wdata;
    logic                   map_re, map_we;
    logic [COORD_W-1:0]     map_raddr, map_waddr;
    logic [GRID_SIDE-1:0]   row_valid_reg, row_valid_next;
    logic [JOB_ID_BITS-1:0] store_mem [GRID_CELLS];
    logic [JOB_ID_BITS-1:0] store_rdata_reg;
    logic                   store_we, store_re;
    logic [2*COORD_W-1:0]   store_raddr;

    // Scan cursor.
    logic [CUR_W-1:0]   cursor_reg, cursor_next;
    logic [COORD_W-1:0] scan_x_reg, scan_y_reg, scan_x_next, scan_y_next;

    // Pending result and output register.
    logic [1:0]             res_status_reg, res_status_next, res_cls_reg, res_cls_next;
    logic [JOB_ID_BITS-1:0] res_num_reg, res_num_next;
    logic [COORD_W-1:0]     res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                   out_valid_reg, out_load;
    logic [1:0]             out_status_reg, out_cls_reg;
    logic [JOB_ID_BITS-1:0] out_num_reg;
    logic [COORD_W-1:0]     out_x_reg, out_y_reg;

    // Z-order address arithmetic.
    logic [SIDE_W-1:0]  side_max, side_sat;
    logic [2:0]         sq_log, blk_log, nbx_log;
    logic [CUR_W-1:0]   limit, blk_off, blk, xb, yb;
    logic [COORD_W-1:0] xlow, ylow, zx, zy;
    logic               scan_done, hit;
    logic [GRID_SIDE-1:0] row_word;

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign given_class = out_cls_reg;
    assign given_number = out_num_reg;
    assign given_x = out_x_reg;
    assign given_y = out_y_reg;

    // The order is derived from the registers on every scan step.
    always_comb
    begin
        side_max = (scene_width_reg > scene_height_reg) ? scene_width_reg : scene_height_reg;
        side_sat = (side_max > SIDE_W'(GRID_SIDE)) ? SIDE_W'(GRID_SIDE) : side_max;
        sq_log = side_log2(side_sat);
        blk_log = whole_square_reg ? sq_log : block_log_reg;
        if (blk_log > sq_log)
        begin
            blk_log = sq_log;
        end
        nbx_log = sq_log - blk_log;
        limit = CUR_W'(1) << {sq_log, 1'b0};
        blk_off = cursor_reg & ((CUR_W'(1) << {blk_log, 1'b0}) - CUR_W'(1));
        blk = cursor_reg >> {blk_log, 1'b0};
        xb = (blk & ((CUR_W'(1) << nbx_log) - CUR_W'(1))) << blk_log;
        yb = (blk >> nbx_log) << blk_log;
        for (int k = 0; k < COORD_W; k++)
        begin
            ylow[k] = blk_off[2*k];
            xlow[k] = blk_off[2*k+1];
        end
        zx = xb[COORD_W-1:0] | xlow;
        zy = yb[COORD_W-1:0] | ylow;
        scan_done = (side_max == '0) || (cursor_reg >= limit);
        row_word = row_valid_reg[scan_y_reg] ? map_rdata_reg : '0;
        hit = row_word[scan_x_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        cursor_next = cursor_reg;
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        row_valid_next = row_valid_reg;
        res_status_next = res_status_reg;
        res_cls_next = res_cls_reg;
        res_num_next = res_num_reg;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        push_en = 1'b0;
        push_q = 2'd0;
        pop_en = 1'b0;
        pop_q = 2'd0;
        map_re = 1'b0;
        map_raddr = req_y_reg;
        map_we = 1'b0;
        map_waddr = req_y_reg;
        map_wdata = row_word;
        store_we = 1'b0;
        store_re = 1'b0;
        store_raddr = {scan_y_reg, scan_x_reg};
        out_load = 1'b0;
        for (int q = 0; q < 3; q++)
        begin
            head_next[q] = head_reg[q];
            count_next[q] = count_reg[q];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = ST_ACCEPTED;
                res_cls_next = CLS_CPU;
                res_num_next = '0;
                res_x_next = '0;
                res_y_next = '0;
                state_next = S_FINISH;
                case (req_op_reg)
                    OP_START:
                    begin
                        row_valid_next = '0;
                        cursor_next = '0;
                        for (int q = 0; q < 3; q++)
                        begin
                            head_next[q] = '0;
                            count_next[q] = '0;
                        end
                    end
                    OP_ADD:
                    begin
                        if (req_cls_reg == CLS_TILE)
                        begin
                            map_re = 1'b1;
                            state_next = S_MAP_WR;
                        end
                        else if (count_reg[queue_of(req_cls_reg)] == CNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = ST_DROPPED;
                        end
                        else
                        begin
                            push_en = 1'b1;
                            push_q = queue_of(req_cls_reg);
                        end
                    end
                    OP_FETCH_CPU:
                    begin
                        if (count_reg[0] != '0)
                        begin
                            pop_en = 1'b1;
                            pop_q = 2'd0;
                            res_cls_next = CLS_CPU;
                            state_next = S_FIFO_OUT;
                        end
                        else
                        begin
                            res_status_next = ST_NONE;
                        end
                    end
                    default:
                    begin
                        // GPU fetch: draw queue first, then the tile map, then the misc queue.
                        if (count_reg[1] != '0)
                        begin
                            pop_en = 1'b1;
                            pop_q = 2'd1;
                            res_cls_next = CLS_DRAW;
                            state_next = S_FIFO_OUT;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_MAP_WR:
            begin
                map_we = 1'b1;
                map_waddr = req_y_reg;
                map_wdata = (row_valid_reg[req_y_reg] ? map_rdata_reg : '0)
                            | (GRID_SIDE'(1) << req_x_reg);
                row_valid_next[req_y_reg] = 1'b1;
                store_we = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN_RD:
            begin
                if (scan_done)
                begin
                    if (count_reg[2] != '0)
                    begin
                        pop_en = 1'b1;
                        pop_q = 2'd2;
                        res_status_next = ST_GIVEN;
                        res_cls_next = CLS_MISC;
                        state_next = S_FIFO_OUT;
                    end
                    else
                    begin
                        res_status_next = ST_NONE;
                        res_cls_next = CLS_CPU;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    map_re = 1'b1;
                    map_raddr = zy;
                    scan_x_next = zx;
                    scan_y_next = zy;
                    cursor_next = cursor_reg + CUR_W'(1);
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    map_we = 1'b1;
                    map_waddr = scan_y_reg;
                    map_wdata = row_word & ~(GRID_SIDE'(1) << scan_x_reg);
                    store_re = 1'b1;
                    state_next = S_TILE_OUT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_TILE_OUT:
            begin
                res_status_next = ST_GIVEN;
                res_cls_next = CLS_TILE;
                res_num_next = store_rdata_reg;
                res_x_next = scan_x_reg;
                res_y_next = scan_y_reg;
                state_next = S_FINISH;
            end
            S_FIFO_OUT:
            begin
                res_status_next = ST_GIVEN;
                res_num_next = fifo_rdata[queue_of(res_cls_reg)][ENT_W-1:2*COORD_W];
                res_x_next = fifo_rdata[queue_of(res_cls_reg)][2*COORD_W-1:COORD_W];
                res_y_next = fifo_rdata[queue_of(res_cls_reg)][COORD_W-1:0];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pop_en)
        begin
            head_next[pop_q] = (head_reg[pop_q] == PTR_W'(QUEUE_DEPTH - 1))
                               ? '0 : head_reg[pop_q] + PTR_W'(1);
            count_next[pop_q] = count_reg[pop_q] - CNT_W'(1);
        end
        if (push_en)
        begin
            count_next[push_q] = count_reg[push_q] + CNT_W'(1);
        end
    end

    // Write slot of the queue being pushed: head plus fill, wrapped once.
    always_comb
    begin
        slot_sum = SUM_W'(head_reg[push_q]) + SUM_W'(count_reg[push_q]);
        if (slot_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
        end
        wslot = slot_sum[PTR_W-1:0];
        for (int q = 0; q < 3; q++)
        begin
            fifo_we[q] = push_en && (push_q == 2'(q));
            fifo_re[q] = pop_en && (pop_q == 2'(q));
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_queue
        logic [ENT_W-1:0] mem [QUEUE_DEPTH];
        logic [ENT_W-1:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (fifo_we[g])
            begin
                mem[wslot] <= {req_num_reg, req_x_reg, req_y_reg};
            end
            if (fifo_re[g])
            begin
                rdata_reg <= mem[head_reg[g]];
            end
        end
        assign fifo_rdata[g] = rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_raddr];
        end
        if (store_we)
        begin
            store_mem[{req_y_reg, req_x_reg}] <= req_num_reg;
        end
        if (store_re)
        begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    // Request latch, scan position and result payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_op_reg <= operation;
            req_cls_reg <= job_class;
            req_num_reg <= job_number;
            req_x_reg <= tile_x;
            req_y_reg <= tile_y;
        end
        scan_x_reg <= scan_x_next;
        scan_y_reg <= scan_y_next;
        res_status_reg <= res_status_next;
        res_cls_reg <= res_cls_next;
        res_num_reg <= res_num_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_cls_reg <= (res_status_reg == ST_GIVEN) ? res_cls_reg : CLS_CPU;
            out_num_reg <= res_num_reg;
            out_x_reg <= res_x_reg;
            out_y_reg <= res_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cursor_reg <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            scene_width_reg <= '0;
            scene_height_reg <= '0;
            whole_square_reg <= 1'b1;
            block_log_reg <= '0;
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q] <= '0;
                count_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cursor_reg <= cursor_next;
            row_valid_reg <= row_valid_next;
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q] <= head_next[q];
                count_reg[q] <= count_next[q];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCENE_WIDTH: scene_width_reg <= cfg_data;
                    CFG_SCENE_HEIGHT: scene_height_reg <= cfg_data;
                    CFG_WHOLE_SQUARE: whole_square_reg <= cfg_data[0];
                    CFG_BLOCK_LOG2: block_log_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/zots_checker.sv
// Port-level checker of the Z-order tile job scheduler, bound to its top level.
// Depends on zots_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zots_checker
    import zots_pkg::*;
#(
    parameter int JOB_ID_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [1:0]             status,
    input logic [1:0]             given_class,
    input logic [JOB_ID_BITS-1:0] given_number,
    input logic [COORD_W-1:0]     given_x,
    input logic [COORD_W-1:0]     given_y
);

    // One request at a time: taking one closes the input side.
    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // A result that is not a given job carries only zero fields.
    `ASSERT_IMP(a_zero_fields, clk, rst_n, out_valid && (status != ST_GIVEN),
                given_class == CLS_CPU && given_number == '0 && given_x == '0 && given_y == '0)

    // A stalled result holds.
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                out_valid && $stable(status) && $stable(given_number))

endmodule

bind z_order_tile_job_scheduler_top zots_checker #(.JOB_ID_BITS(JOB_ID_BITS)) u_zots_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .given_class(given_class),
    .given_number(given_number),
    .given_x(given_x),
    .given_y(given_y)
);
